// ----- sv/frm_pkg.sv -----
// ----------------------------------------------------------------------------
// frm_pkg - shared types for the fraction reduce and max core
// State encoding, the controller-to-datapath command group and the status
// group returned by the datapath.
// ----------------------------------------------------------------------------
package frm_pkg;

   localparam int DefWidth = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_GCD_INIT,
      ST_GCD,
      ST_DIVN_INIT,
      ST_DIVN_RUN,
      ST_DIVD_INIT,
      ST_DIVD_RUN,
      ST_NEXT,
      ST_MUL_A,
      ST_MUL_B,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;    // register a new item
      logic gcd_init;   // load gcd operands of the selected fraction
      logic gcd_step;   // one binary gcd step
      logic g_load;     // divisor <= gcd
      logic div_init;   // load dividend, clear remainder and count
      logic div_den;    // dividend is the denominator (else numerator)
      logic div_step;   // one restoring division step
      logic store_num;  // keep signed reduced numerator
      logic store_den;  // keep reduced denominator
      logic mul_en;     // cross product into its register
      logic mul_sel;    // 0: n1*d2, 1: n2*d1
      logic frac;       // 0: first fraction, 1: second
      logic rsp_load;   // result into the output register
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic gcd_done;
      logic div_done;
   } status_type;

endpackage

// ----- sv/frm_ctrl.sv -----
// ----------------------------------------------------------------------------
// frm_ctrl - sequencing controller
// Walks one item through check, gcd, two divisions per fraction, cross
// products and output hand-over; a zero denominator skips straight to it.
// ----------------------------------------------------------------------------
module frm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   input  frm_pkg::status_type status,
   output frm_pkg::cmd_type    cmd
);

   frm_pkg::state_type state_ff, state_in;
   logic               frac_ff, frac_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frm_pkg::ST_IDLE;
         frac_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frac_ff      <= frac_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      frac_in    = frac_ff;
      cmd        = '0;
      cmd.frac   = frac_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         frm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = frm_pkg::ST_CHECK;
            end
         end
         frm_pkg::ST_CHECK: begin
            if (status.den_zero) begin
               state_in = frm_pkg::ST_FINISH;
            end else begin
               frac_in  = 1'b0;
               state_in = frm_pkg::ST_GCD_INIT;
            end
         end
         frm_pkg::ST_GCD_INIT: begin
            cmd.gcd_init = 1'b1;
            state_in     = frm_pkg::ST_GCD;
         end
         frm_pkg::ST_GCD: begin
            if (status.gcd_done) begin
               state_in = frm_pkg::ST_DIVN_INIT;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         frm_pkg::ST_DIVN_INIT: begin
            cmd.g_load   = 1'b1;
            cmd.div_init = 1'b1;
            state_in     = frm_pkg::ST_DIVN_RUN;
         end
         frm_pkg::ST_DIVN_RUN: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = frm_pkg::ST_DIVD_INIT;
            end
         end
         frm_pkg::ST_DIVD_INIT: begin
            cmd.store_num = 1'b1;
            cmd.div_init  = 1'b1;
            cmd.div_den   = 1'b1;
            state_in      = frm_pkg::ST_DIVD_RUN;
         end
         frm_pkg::ST_DIVD_RUN: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = frm_pkg::ST_NEXT;
            end
         end
         frm_pkg::ST_NEXT: begin
            cmd.store_den = 1'b1;
            if (!frac_ff) begin
               frac_in  = 1'b1;
               state_in = frm_pkg::ST_GCD_INIT;
            end else begin
               state_in = frm_pkg::ST_MUL_A;
            end
         end
         frm_pkg::ST_MUL_A: begin
            cmd.mul_en = 1'b1;
            state_in   = frm_pkg::ST_MUL_B;
         end
         frm_pkg::ST_MUL_B: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = 1'b1;
            state_in    = frm_pkg::ST_FINISH;
         end
         frm_pkg::ST_FINISH: begin
            // wait here only while an older result is still unclaimed
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = frm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frm_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

endmodule

// ----- sv/frm_datapath.sv -----
// ----------------------------------------------------------------------------
// frm_datapath - operand store, binary gcd, restoring divider, multiplier
// All arithmetic for one item; every step is started by the controller.
// ----------------------------------------------------------------------------
module frm_datapath #(
   parameter int WIDTH = frm_pkg::DefWidth
) (
   input  logic                      clock,
   input  frm_pkg::cmd_type          cmd,
   output frm_pkg::status_type       status,
   input  logic signed [WIDTH-1:0]   a_num,
   input  logic signed [WIDTH-1:0]   a_den,
   input  logic signed [WIDTH-1:0]   b_num,
   input  logic signed [WIDTH-1:0]   b_den,
   output logic signed [WIDTH:0]     max_num,
   output logic        [WIDTH-1:0]   max_den,
   output logic                      undefined,
   output logic                      picked_second
);

   localparam int KW = $clog2(WIDTH);
   localparam int PW = 2 * WIDTH + 2;

   // captured magnitudes and result signs
   logic [WIDTH-1:0] a_nmag_ff, a_nmag_in, a_dmag_ff, a_dmag_in;
   logic [WIDTH-1:0] b_nmag_ff, b_nmag_in, b_dmag_ff, b_dmag_in;
   logic             a_neg_ff, a_neg_in, b_neg_ff, b_neg_in;
   // binary gcd
   logic [WIDTH-1:0] u_ff, u_in, v_ff, v_in;
   logic [KW-1:0]    k_ff, k_in;
   // divider
   logic [WIDTH-1:0] div_ff, div_in, rem_ff, rem_in, quo_ff, quo_in;
   logic [KW-1:0]    cnt_ff, cnt_in;
   // reduced fractions and cross products
   logic signed [WIDTH:0]  a_rnum_ff, a_rnum_in, b_rnum_ff, b_rnum_in;
   logic [WIDTH-1:0]       a_rden_ff, a_rden_in, b_rden_ff, b_rden_in;
   logic signed [PW-1:0]   prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   // output register
   logic signed [WIDTH:0]  max_num_ff, max_num_in;
   logic [WIDTH-1:0]       max_den_ff, max_den_in;
   logic                   undef_ff, undef_in, second_ff, second_in;

   logic [WIDTH-1:0]       trial;
   logic [WIDTH:0]         diff;
   logic [WIDTH:0]         qx;
   logic signed [WIDTH:0]  rnum;
   logic signed [WIDTH:0]  op_n;
   logic signed [WIDTH:0]  op_d;
   logic signed [PW-1:0]   prod;
   logic                   second;

   function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] x);
      return x[WIDTH-1] ? (~x + 1'b1) : x;
   endfunction

   assign status.den_zero = (a_dmag_ff == '0) || (b_dmag_ff == '0);
   assign status.gcd_done = (u_ff == '0);
   assign status.div_done = (cnt_ff == KW'(WIDTH - 1));

   assign trial = {rem_ff[WIDTH-2:0], quo_ff[WIDTH-1]};
   assign diff  = {1'b0, trial} - {1'b0, div_ff};
   assign qx    = {1'b0, quo_ff};
   assign rnum  = (cmd.frac ? b_neg_ff : a_neg_ff) ? $signed(~qx + 1'b1) : $signed(qx);

   assign op_n   = cmd.mul_sel ? b_rnum_ff : a_rnum_ff;
   assign op_d   = $signed({1'b0, cmd.mul_sel ? a_rden_ff : b_rden_ff});
   assign prod   = op_n * op_d;
   assign second = !(prod_a_ff > prod_b_ff);

   always_comb begin
      a_nmag_in  = a_nmag_ff;  a_dmag_in = a_dmag_ff;  a_neg_in = a_neg_ff;
      b_nmag_in  = b_nmag_ff;  b_dmag_in = b_dmag_ff;  b_neg_in = b_neg_ff;
      u_in       = u_ff;       v_in      = v_ff;       k_in     = k_ff;
      div_in     = div_ff;     rem_in    = rem_ff;     quo_in   = quo_ff;
      cnt_in     = cnt_ff;
      a_rnum_in  = a_rnum_ff;  b_rnum_in = b_rnum_ff;
      a_rden_in  = a_rden_ff;  b_rden_in = b_rden_ff;
      prod_a_in  = prod_a_ff;  prod_b_in = prod_b_ff;
      max_num_in = max_num_ff; max_den_in = max_den_ff;
      undef_in   = undef_ff;   second_in  = second_ff;

      if (cmd.capture) begin
         a_nmag_in = mag(a_num);
         a_dmag_in = mag(a_den);
         a_neg_in  = a_num[WIDTH-1] ^ a_den[WIDTH-1];
         b_nmag_in = mag(b_num);
         b_dmag_in = mag(b_den);
         b_neg_in  = b_num[WIDTH-1] ^ b_den[WIDTH-1];
      end

      // gcd(u, v) * 2^k is invariant; v never reaches zero
      if (cmd.gcd_init) begin
         u_in = cmd.frac ? b_nmag_ff : a_nmag_ff;
         v_in = cmd.frac ? b_dmag_ff : a_dmag_ff;
         k_in = '0;
      end else if (cmd.gcd_step) begin
         if (!u_ff[0] && !v_ff[0]) begin
            u_in = u_ff >> 1;
            v_in = v_ff >> 1;
            k_in = k_ff + KW'(1);
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_in = u_ff - v_ff;
         end else begin
            v_in = v_ff - u_ff;
         end
      end

      if (cmd.g_load) begin
         div_in = v_ff << k_ff;
      end

      if (cmd.div_init) begin
         if (cmd.div_den) begin
            quo_in = cmd.frac ? b_dmag_ff : a_dmag_ff;
         end else begin
            quo_in = cmd.frac ? b_nmag_ff : a_nmag_ff;
         end
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + KW'(1);
      end

      if (cmd.store_num) begin
         if (cmd.frac) begin
            b_rnum_in = rnum;
         end else begin
            a_rnum_in = rnum;
         end
      end

      if (cmd.store_den) begin
         if (cmd.frac) begin
            b_rden_in = quo_ff;
         end else begin
            a_rden_in = quo_ff;
         end
      end

      if (cmd.mul_en) begin
         if (cmd.mul_sel) begin
            prod_b_in = prod;
         end else begin
            prod_a_in = prod;
         end
      end

      if (cmd.rsp_load) begin
         if (status.den_zero) begin
            max_num_in = '0;
            max_den_in = '0;
            undef_in   = 1'b1;
            second_in  = 1'b0;
         end else begin
            max_num_in = second ? b_rnum_ff : a_rnum_ff;
            max_den_in = second ? b_rden_ff : a_rden_ff;
            undef_in   = 1'b0;
            second_in  = second;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_nmag_ff  <= a_nmag_in;  a_dmag_ff  <= a_dmag_in;  a_neg_ff <= a_neg_in;
      b_nmag_ff  <= b_nmag_in;  b_dmag_ff  <= b_dmag_in;  b_neg_ff <= b_neg_in;
      u_ff       <= u_in;       v_ff       <= v_in;       k_ff     <= k_in;
      div_ff     <= div_in;     rem_ff     <= rem_in;     quo_ff   <= quo_in;
      cnt_ff     <= cnt_in;
      a_rnum_ff  <= a_rnum_in;  b_rnum_ff  <= b_rnum_in;
      a_rden_ff  <= a_rden_in;  b_rden_ff  <= b_rden_in;
      prod_a_ff  <= prod_a_in;  prod_b_ff  <= prod_b_in;
      max_num_ff <= max_num_in; max_den_ff <= max_den_in;
      undef_ff   <= undef_in;   second_ff  <= second_in;
   end

   assign max_num       = max_num_ff;
   assign max_den       = max_den_ff;
   assign undefined     = undef_ff;
   assign picked_second = second_ff;

endmodule

// ----- sv/fraction_reduce_and_max_core.sv -----
// Undefined items (a zero denominator) skip the gcd and divisions and go straight to the
//   output register; all others run the binary gcd and both divisions for each fraction.
// One item at a time: the next input transfer is taken only once the previous result has
//   entered the output register, as the restoring divider and gcd loop are shared.
// Reset: synchronous, active high; clears controller state and the output valid.
// ----------------------------------------------------------------------------
// fraction_reduce_and_max_core - reduce two fractions and give the larger
// Each fraction is divided by the gcd of its magnitudes (binary gcd, then two
// restoring divisions on a shared divider), signs are folded into the
// numerator, and the two are compared by exact cross products.
// ----------------------------------------------------------------------------
module fraction_reduce_and_max_core #(
   parameter int WIDTH = frm_pkg::DefWidth
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((4*WIDTH+7)/8)*8-1:0]          req_tdata,  // a_num, a_den, b_num, b_den
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((2*WIDTH+1+7)/8)*8-1:0]        rsp_tdata,  // max_num, max_den
   output logic [1:0]                            rsp_tuser   // undefined, picked_second
);

   localparam int RspW = ((2 * WIDTH + 1 + 7) / 8) * 8;

   frm_pkg::cmd_type    cmd;
   frm_pkg::status_type status;

   logic signed [WIDTH:0]   max_num;
   logic        [WIDTH-1:0] max_den;
   logic                    undefined;
   logic                    picked_second;

   // controller: one item in flight, result parked in the output register
   frm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: fields are sliced straight out of the request word
   frm_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .status        (status),
      .a_num         ($signed(req_tdata[WIDTH-1:0])),
      .a_den         ($signed(req_tdata[2*WIDTH-1:WIDTH])),
      .b_num         ($signed(req_tdata[3*WIDTH-1:2*WIDTH])),
      .b_den         ($signed(req_tdata[4*WIDTH-1:3*WIDTH])),
      .max_num       (max_num),
      .max_den       (max_den),
      .undefined     (undefined),
      .picked_second (picked_second)
   );

   // numerator in the low bits, denominator above, zero padded to bytes
   assign rsp_tdata = RspW'({max_den, max_num});
   assign rsp_tuser = {picked_second, undefined};

   // an undefined result carries nothing else
   a_undef_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("undefined result with non-zero payload");

   // a defined result always has a positive denominator
   a_den_positive : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> max_den != '0)
      else $error("reduced denominator is zero");

   // the gcd loop is never stepped once it has converged
   a_gcd_guard : assert property (@(posedge clock) disable iff (reset)
      cmd.gcd_step |-> !status.gcd_done)
      else $error("gcd stepped after completion");

   // after taking an item the block is busy
   a_busy_after_take : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transfer accepted while working");

endmodule
